// File: rtl/stic_pkg.sv
// Shared definitions for the sorted table: command and status codes, field widths,
// the per-cell control struct and the signed-order key function.
// No dependencies.
package stic_pkg;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int FILL_W   = 7;

  // Command codes carried in the input beat.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  // Status codes carried in the result beat.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Update strobes broadcast from the top level to every cell.
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

  // Flipping the sign bit makes unsigned order match signed order.
  function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] bits);
    order_key = {~bits[VALUE_W-1], bits[VALUE_W-2:0]};
  endfunction

endpackage

// File: rtl/stic_cell.sv
// One slot of the sorted table: holds an entry, compares it with the command value
// and shifts in a neighbor's entry on insert or delete. Depends on stic_pkg.
module stic_cell import stic_pkg::*; #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 7
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [VALUE_W-1:0] value,
  input  logic [CNT_W-1:0]   held_count,
  input  logic               left_ge,
  input  logic [VALUE_W-1:0] left_entry,
  input  logic [VALUE_W-1:0] right_entry,
  output logic [VALUE_W-1:0] entry,
  output logic               ge,
  output logic               eq,
  output logic               boundary
);

  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;
  logic               below;

  // A slot at or past the fill count acts as larger than any value.
  assign below    = CNT_W'(CELL_IDX) < held_count;
  assign ge       = !below || (order_key(value) <= order_key(entry_r));
  assign eq       = below && (value == entry_r);
  assign boundary = ge && !left_ge;
  assign entry    = entry_r;

  // Insert moves entries up from the boundary; delete pulls them down.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && ge) begin
      entry_nxt = boundary ? value : left_entry;
    end else if (ctl.del_en && ge) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: rtl/stic_pos_enc.sv
// Encodes the one-hot boundary flags of the cell row into an index.
// Depends on nothing but its parameters.
module stic_pos_enc #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic [DEPTH-1:0] onehot,
  output logic [IDX_W-1:0] index
);

  // With at most one flag set, OR-ing the indices of set flags gives the index.
  always_comb begin
    index = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (onehot[i]) begin
        index = index | IDX_W'(i);
      end
    end
  end

endmodule

// File: rtl/sorted_table_insert_delete_find.sv
// Sorted table of signed 32-bit values with insert, delete and find. Every entry
// lives in its own cell, and all cells compare the command value at once, so a beat
// is accepted in every cycle unless the full output register is stalled, and its
// result appears in the output register in the cycle after it is accepted, set by
// the single compare-and-shift step of the cell row. Inputs are taken whenever the
// output register is empty or being drained. Insert goes before the first entry
// that is greater or equal; delete and find act on the lowest-indexed equal entry.
// Depends on stic_pkg, stic_cell and stic_pos_enc.
module sorted_table_insert_delete_find import stic_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] cmd, [33:2] value, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [7:2] position, [14:8] fill_count
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value;
  logic               accept;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  logic               out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_nxt;
  logic [FILL_W-1:0]  fill_r;

  cell_ctl_t              ctl;
  logic [VALUE_W-1:0]     entry_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ge_w;
  logic [TABLE_DEPTH-1:0] eq_w;
  logic [TABLE_DEPTH-1:0] bnd_w;
  logic [IDX_W-1:0]       bnd_idx;
  logic                   found;
  logic                   full;

  // Input beat fields and handshake.
  assign cmd       = in_tdata[1:0];
  assign value     = in_tdata[33:2];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign found = |eq_w;
  assign full  = count_r >= CNT_W'(TABLE_DEPTH);

  assign ctl.ins_en = accept && (cmd == CMD_INSERT) && !full;
  assign ctl.del_en = accept && (cmd == CMD_DELETE) && found;

  // Row of cells, each linked to its neighbors' entries and compare flags.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic               left_ge;
    logic [VALUE_W-1:0] left_entry;
    logic [VALUE_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_ge    = 1'b0;
      assign left_entry = value;
    end else begin : g_mid
      assign left_ge    = ge_w[i-1];
      assign left_entry = entry_w[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_body
      assign right_entry = entry_w[i+1];
    end

    stic_cell #(
      .CELL_IDX (i),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .value       (value),
      .held_count  (count_r),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_w[i]),
      .ge          (ge_w[i]),
      .eq          (eq_w[i]),
      .boundary    (bnd_w[i])
    );
  end

  stic_pos_enc #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_pos_enc (
    .onehot (bnd_w),
    .index  (bnd_idx)
  );

  // Status, position and count update for the accepted command.
  always_comb begin
    status_nxt = ST_NOT_FOUND;
    pos_nxt    = '0;
    count_nxt  = count_r;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          pos_nxt    = POS_W'(32'(bnd_idx));
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (found) begin
          status_nxt = ST_OK;
          pos_nxt    = POS_W'(32'(bnd_idx));
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      CMD_FIND: begin
        if (found) begin
          status_nxt = ST_OK;
          pos_nxt    = POS_W'(32'(bnd_idx));
        end
      end
      default: begin
        status_nxt = ST_NOT_FOUND;
      end
    endcase
  end

  // Fill count and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
      fill_r   <= FILL_W'(32'(count_nxt));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, fill_r, pos_r, status_r};

  // The fill count never passes the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count above table depth");

  // At most one cell sees the insert boundary.
  a_bnd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bnd_w))
    else $error("more than one boundary cell");

  // A successful insert grows the table by exactly one entry.
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the table");

  // A successful delete shrinks the table by exactly one entry.
  a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.del_en |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("delete did not shrink the table");

  // Any match lies inside the filled part and sits at the boundary cell.
  a_match_bnd: assert property (@(posedge clk) disable iff (!rst_n)
    found |-> eq_w[bnd_idx])
    else $error("first match is not at the boundary cell");

endmodule

// File: tb/sv/stic_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the sorted table: a shadow copy of the table and the queue of replies it owes.
// Depends on stic_pkg for the command and status codes.
package stic_tb_pkg;
  import stic_pkg::*;

  localparam int TABLE_SLOTS = 64;

  // The fourth command code has no name in the design package; the block ignores it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [FILL_W-1:0]   fill_count;
  } reply_t;

  class sorted_table_tracker;
    logic signed [VALUE_W-1:0] slots [TABLE_SLOTS];
    int held;
    reply_t replies_due [$];
    int failures;

    function new();
      held = 0;
      failures = 0;
    endfunction

    // Lowest slot holding the value, or held when it is absent.
    function int lowest_match(logic signed [VALUE_W-1:0] value);
      for (int i = 0; i < held; i++) begin
        if (slots[i] == value) return i;
      end
      return held;
    endfunction

    // Apply one accepted command to the shadow table and queue the reply it owes.
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] value);
      reply_t r;
      int idx;
      r.status = ST_NOT_FOUND;
      r.position = '0;
      case (cmd)
        CMD_INSERT: begin
          if (held >= TABLE_SLOTS) begin
            r.status = ST_FULL;
          end else begin
            // New value goes before the first entry that is greater or equal.
            idx = 0;
            while (idx < held && value > slots[idx]) idx++;
            for (int k = held; k > idx; k--) slots[k] = slots[k-1];
            slots[idx] = value;
            held++;
            r.status = ST_OK;
            r.position = idx[POS_W-1:0];
          end
        end
        CMD_DELETE: begin
          idx = lowest_match(value);
          if (idx < held) begin
            for (int k = idx; k + 1 < held; k++) slots[k] = slots[k+1];
            held--;
            r.status = ST_OK;
            r.position = idx[POS_W-1:0];
          end
        end
        CMD_FIND: begin
          idx = lowest_match(value);
          if (idx < held) begin
            r.status = ST_OK;
            r.position = idx[POS_W-1:0];
          end
        end
        default: begin
          // Unused code: nothing changes and the reply says not found.
        end
      endcase
      r.fill_count = held[FILL_W-1:0];
      replies_due.push_back(r);
    endfunction

    function void field_mismatch(string name, int want, int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    endfunction

    // Compare a result beat with the oldest reply still owed.
    function void check_reply(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position,
                              logic [FILL_W-1:0] fill_count);
      reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: result beat with none owed, expected nothing, actual %0d/%0d/%0d",
                 $time, status, position, fill_count);
        failures++;
        return;
      end
      want = replies_due.pop_front();
      if (status !== want.status) field_mismatch("status", want.status, status);
      if (position !== want.position) field_mismatch("position", want.position, position);
      if (fill_count !== want.fill_count)
        field_mismatch("fill_count", want.fill_count, fill_count);
    endfunction
  endclass

endpackage

// File: tb/sv/sorted_table_insert_delete_find_test.sv
`timescale 1ns / 1ps
// Top of the sorted table testbench: clock, reset, beat drivers, result monitor and watchdog.
// Depends on stic_pkg, stic_tb_pkg and the sorted_table_insert_delete_find block.
module sorted_table_insert_delete_find_test;
  import stic_pkg::*;
  import stic_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [1:0] cmd, [33:2] value, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [1:0] status, [7:2] position, [14:8] fill_count

  sorted_table_tracker tracker;
  bit stalls_on = 1'b1;
  int quiet_cycles = 0;

  sorted_table_insert_delete_find dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one command beat, optionally after an idle gap, and hold it until it is taken.
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] value,
                           bit idle_on);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, value, cmd};
    do @(posedge clk); while (!in_tready);
    tracker.note_command(cmd, value);
  endtask

  // Values cluster around zero so that duplicates and hits are common.
  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0, 1: return $signed($urandom_range(0, 24)) - 12;
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Mostly a value already in the table, so that delete and find usually hit.
  function automatic logic signed [VALUE_W-1:0] held_value();
    if (tracker.held > 0 && $urandom_range(0, 3) != 0)
      return tracker.slots[$urandom_range(0, tracker.held - 1)];
    return random_value();
  endfunction

  // One stretch of random commands with the given insert, delete and find weights.
  task automatic run_phase(int beats, int ins_w, int del_w, int find_w, bit allow_idle);
    logic [CMD_W-1:0] cmd;
    int roll;
    bit idle_on;
    idle_on = 1'b0;
    for (int n = 0; n < beats; n++) begin
      if (n % 30 == 0) idle_on = allow_idle && ($urandom_range(0, 2) != 0);
      roll = $urandom_range(0, 99);
      if (roll < ins_w) cmd = CMD_INSERT;
      else if (roll < ins_w + del_w) cmd = CMD_DELETE;
      else if (roll < ins_w + del_w + find_w) cmd = CMD_FIND;
      else cmd = CMD_UNUSED;
      send_beat(cmd, (cmd == CMD_INSERT) ? random_value() : held_value(), idle_on);
    end
  endtask

  // Result side: ready drops in random bursts, with long stretches of steady ready.
  initial begin
    out_tready <= 1'b0;
    repeat (7) @(posedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Every result beat is checked against the oldest reply owed.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_reply(out_tdata[1:0], out_tdata[7:2], out_tdata[14:8]);
  end

  // Watchdog: too many cycles in a row without a beat on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    tracker = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, unused code, extremes, duplicates and misses.
    send_beat(CMD_FIND,   5, 1'b0);
    send_beat(CMD_DELETE, 5, 1'b0);
    send_beat(CMD_UNUSED, 0, 1'b0);
    send_beat(CMD_INSERT, 0, 1'b0);
    send_beat(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
    send_beat(CMD_INSERT, 32'sh8000_0000, 1'b0);
    send_beat(CMD_INSERT, -1, 1'b0);
    send_beat(CMD_INSERT, 0, 1'b0);
    send_beat(CMD_INSERT, 1, 1'b0);
    send_beat(CMD_FIND,   0, 1'b0);
    send_beat(CMD_FIND,   32'sh7fff_ffff, 1'b0);
    send_beat(CMD_FIND,   32'sh8000_0000, 1'b0);
    send_beat(CMD_FIND,   7, 1'b0);
    send_beat(CMD_UNUSED, -1, 1'b0);
    send_beat(CMD_DELETE, 0, 1'b0);
    send_beat(CMD_DELETE, 0, 1'b0);
    send_beat(CMD_DELETE, 0, 1'b0);
    send_beat(CMD_DELETE, 32'sh8000_0000, 1'b0);
    send_beat(CMD_DELETE, 32'sh7fff_ffff, 1'b0);
    send_beat(CMD_FIND,   -1, 1'b0);

    // Insert-heavy stretch fills the table and keeps hitting the full case.
    run_phase(180, 70, 10, 15, 1'b1);
    // Delete-heavy stretch drains it back to empty and past.
    run_phase(200, 15, 60, 20, 1'b1);
    // Mixed tail with no idling on either side.
    stalls_on = 1'b0;
    run_phase(150, 40, 25, 30, 1'b0);
    in_tvalid <= 1'b0;

    while (tracker.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
